>>> sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Channel resolution; all-ones stands for 1.0.
    localparam int unsigned CHANNEL_BITS = 8;
    localparam int unsigned MAXV         = (1 << CHANNEL_BITS) - 1;
    localparam int unsigned HALF_MAXV    = MAXV / 2;

    // Hue geometry in whole degrees.
    localparam int unsigned HUE_BITS       = 9;
    localparam int unsigned FULL_TURN      = 360;
    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned HALF_SECTOR    = DEG_PER_SECTOR / 2;
    localparam int unsigned REM_BITS       = 6;

    // Ramp product chroma * (0..60) + 30 fits in RAMP_BITS bits.
    localparam int unsigned RAMP_BITS = CHANNEL_BITS + REM_BITS;

    // Reciprocal of 60 scaled by 2^RAMP_SHIFT; the estimate is at most one low.
    localparam int unsigned RAMP_SHIFT       = RAMP_BITS;
    localparam int unsigned RAMP_RECIP       = (1 << RAMP_SHIFT) / DEG_PER_SECTOR;
    localparam int unsigned RAMP_RECIP_BITS  = CHANNEL_BITS + 1;
    localparam int unsigned RAMP_PROD_BITS   = RAMP_BITS + RAMP_RECIP_BITS;

    // Number of register stages in the datapath.
    localparam int unsigned PIPE_STAGES = 7;

    // Hue sectors, 60 degrees each, starting at red.
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW   = 3'd0,
        SECTOR_YELLOW_GREEN = 3'd1,
        SECTOR_GREEN_CYAN   = 3'd2,
        SECTOR_CYAN_BLUE    = 3'd3,
        SECTOR_BLUE_MAGENTA = 3'd4,
        SECTOR_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

endpackage

>>> sv/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// -------   ----------------------   ---------------------------------------------
// input     in_valid / in_ready      hue_degrees[8:0], saturation, brightness_value
// output    out_valid / out_ready    red_level, green_level, blue_level
// config    cfg_valid / cfg_ready    square_output_enable
//
// A request passes through the seven register stages of the datapath, and one
// request is taken every cycle unless an output stall holds in_ready low.
// Reset clears the stage valid bits and the squaring mode; no clearing pass.
// Each stage loads whenever it is empty or the stage after it moves, so an
// output stall fills the bubbles first and only then holds in_ready low.

module hsv_to_rgb_converter_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [hsv2rgb_pkg::HUE_BITS-1:0]      hue_degrees,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]  saturation,
    input  logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]  brightness_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]  red_level,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]  green_level,
    output logic [hsv2rgb_pkg::CHANNEL_BITS-1:0]  blue_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  square_output_enable
);

    localparam int unsigned B  = hsv2rgb_pkg::CHANNEL_BITS;
    localparam int unsigned NS = hsv2rgb_pkg::PIPE_STAGES;
    localparam int unsigned HB = hsv2rgb_pkg::HUE_BITS;
    localparam int unsigned RB = hsv2rgb_pkg::RAMP_BITS;
    localparam int unsigned PB = hsv2rgb_pkg::RAMP_PROD_BITS;
    localparam int unsigned SH = hsv2rgb_pkg::RAMP_SHIFT;

    // Rounded-down division of a 2B-bit value by MAXV = 2^B - 1.
    // Writing num = a * 2^B + b gives num / MAXV = a + (a + b) / MAXV, so
    // (num + a) >> B is either exact or one low; one compare fixes it.
    function automatic logic [B-1:0] div_maxv(input logic [2*B-1:0] num);
        logic [2*B:0]   sum;
        logic [B-1:0]   q_est;
        logic [2*B:0]   rem_w;
        sum   = {1'b0, num} + {{(B+1){1'b0}}, num[2*B-1:B]};
        q_est = sum[2*B-1:B];
        rem_w = {1'b0, num} - {1'b0, q_est, {B{1'b0}}} + {{(B+1){1'b0}}, q_est};
        return q_est + ((rem_w >= (2*B+1)'(hsv2rgb_pkg::MAXV)) ? B'(1) : B'(0));
    endfunction

    // Stage valid bits and load enables.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   adv;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = ~valid_reg[k] | adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NS-1];
    assign cfg_ready = 1'b1;

    // Squaring mode register.
    logic square_en_reg;
    logic square_en_next;

    always_comb
    begin
        square_en_next = square_en_reg;
        if (cfg_valid)
        begin
            square_en_next = square_output_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            square_en_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            square_en_reg <= square_en_next;
        end
    end

    // Stage 1: fold hue into one turn and form value * saturation + half.
    logic [HB-1:0]  s1_hue_reg,  s1_hue_next;
    logic [2*B-1:0] s1_prod_reg, s1_prod_next;
    logic [B-1:0]   s1_val_reg,  s1_val_next;

    always_comb
    begin
        if (hue_degrees >= HB'(hsv2rgb_pkg::FULL_TURN))
        begin
            s1_hue_next = hue_degrees - HB'(hsv2rgb_pkg::FULL_TURN);
        end
        else
        begin
            s1_hue_next = hue_degrees;
        end
        s1_prod_next = ((2*B)'(saturation) * (2*B)'(brightness_value))
                       + (2*B)'(hsv2rgb_pkg::HALF_MAXV);
        s1_val_next  = brightness_value;
    end

    // Stage 2: chroma, plus sector and offset within the sector.
    hsv2rgb_pkg::sector_t        s2_sector_reg, s2_sector_next;
    logic [hsv2rgb_pkg::REM_BITS-1:0] s2_rem_reg, s2_rem_next;
    logic [B-1:0]                s2_chroma_reg, s2_chroma_next;
    logic [B-1:0]                s2_val_reg,    s2_val_next;
    logic [HB-1:0]               s2_base;
    logic [HB-1:0]               s2_off;

    always_comb
    begin
        if (s1_hue_reg >= HB'(5 * hsv2rgb_pkg::DEG_PER_SECTOR))
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_MAGENTA_RED;
        end
        else if (s1_hue_reg >= HB'(4 * hsv2rgb_pkg::DEG_PER_SECTOR))
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_BLUE_MAGENTA;
        end
        else if (s1_hue_reg >= HB'(3 * hsv2rgb_pkg::DEG_PER_SECTOR))
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_CYAN_BLUE;
        end
        else if (s1_hue_reg >= HB'(2 * hsv2rgb_pkg::DEG_PER_SECTOR))
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_GREEN_CYAN;
        end
        else if (s1_hue_reg >= HB'(hsv2rgb_pkg::DEG_PER_SECTOR))
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_YELLOW_GREEN;
        end
        else
        begin
            s2_sector_next = hsv2rgb_pkg::SECTOR_RED_YELLOW;
        end

        s2_base = HB'(s2_sector_next) * HB'(hsv2rgb_pkg::DEG_PER_SECTOR);
        s2_off  = s1_hue_reg - s2_base;
        s2_rem_next    = s2_off[hsv2rgb_pkg::REM_BITS-1:0];
        s2_chroma_next = div_maxv(s1_prod_reg);
        s2_val_next    = s1_val_reg;
    end

    // Stage 3: ramp numerator; odd sectors ramp down.
    logic [RB-1:0]        s3_ramp_reg,   s3_ramp_next;
    logic [B-1:0]         s3_chroma_reg, s3_chroma_next;
    logic [B-1:0]         s3_m_reg,      s3_m_next;
    hsv2rgb_pkg::sector_t s3_sector_reg, s3_sector_next;
    logic [hsv2rgb_pkg::REM_BITS-1:0] s3_k;

    always_comb
    begin
        if (s2_sector_reg[0])
        begin
            s3_k = hsv2rgb_pkg::REM_BITS'(hsv2rgb_pkg::DEG_PER_SECTOR) - s2_rem_reg;
        end
        else
        begin
            s3_k = s2_rem_reg;
        end
        s3_ramp_next   = (RB'(s2_chroma_reg) * RB'(s3_k)) + RB'(hsv2rgb_pkg::HALF_SECTOR);
        s3_chroma_next = s2_chroma_reg;
        s3_m_next      = s2_val_reg - s2_chroma_reg;
        s3_sector_next = s2_sector_reg;
    end

    // Stage 4: quotient estimate of the ramp by 60 through the reciprocal.
    logic [B-1:0]         s4_qest_reg,   s4_qest_next;
    logic [RB-1:0]        s4_ramp_reg,   s4_ramp_next;
    logic [B-1:0]         s4_chroma_reg, s4_chroma_next;
    logic [B-1:0]         s4_m_reg,      s4_m_next;
    hsv2rgb_pkg::sector_t s4_sector_reg, s4_sector_next;
    logic [PB-1:0]        s4_prod;

    always_comb
    begin
        s4_prod        = PB'(s3_ramp_reg) * PB'(hsv2rgb_pkg::RAMP_RECIP);
        s4_qest_next   = s4_prod[SH+B-1:SH];
        s4_ramp_next   = s3_ramp_reg;
        s4_chroma_next = s3_chroma_reg;
        s4_m_next      = s3_m_reg;
        s4_sector_next = s3_sector_reg;
    end

    // Stage 5: correct the ramp quotient, place channels, add the offset.
    hsv2rgb_pkg::chan_t s5_chan_reg  [3];
    hsv2rgb_pkg::chan_t s5_chan_next [3];
    logic [RB-1:0]      s5_rem;
    logic [B-1:0]       s5_x;
    logic [B-1:0]       s5_c;

    always_comb
    begin
        s5_rem = s4_ramp_reg - ((RB'(s4_qest_reg) << 6) - (RB'(s4_qest_reg) << 2));
        s5_x   = s4_qest_reg
                 + ((s5_rem >= RB'(hsv2rgb_pkg::DEG_PER_SECTOR)) ? B'(1) : B'(0));
        s5_c   = s4_chroma_reg;
        case (s4_sector_reg)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                s5_chan_next[0] = s5_c;  s5_chan_next[1] = s5_x;  s5_chan_next[2] = '0;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                s5_chan_next[0] = s5_x;  s5_chan_next[1] = s5_c;  s5_chan_next[2] = '0;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                s5_chan_next[0] = '0;    s5_chan_next[1] = s5_c;  s5_chan_next[2] = s5_x;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                s5_chan_next[0] = '0;    s5_chan_next[1] = s5_x;  s5_chan_next[2] = s5_c;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                s5_chan_next[0] = s5_x;  s5_chan_next[1] = '0;    s5_chan_next[2] = s5_c;
            end
            default:
            begin
                s5_chan_next[0] = s5_c;  s5_chan_next[1] = '0;    s5_chan_next[2] = s5_x;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            s5_chan_next[i] = s5_chan_next[i] + s4_m_reg;
        end
    end

    // Stage 6: square each channel, with half added for rounding.
    logic [2*B-1:0]     s6_sq_reg    [3];
    logic [2*B-1:0]     s6_sq_next   [3];
    hsv2rgb_pkg::chan_t s6_chan_reg  [3];
    hsv2rgb_pkg::chan_t s6_chan_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_sq_next[i]   = ((2*B)'(s5_chan_reg[i]) * (2*B)'(s5_chan_reg[i]))
                              + (2*B)'(hsv2rgb_pkg::HALF_MAXV);
            s6_chan_next[i] = s5_chan_reg[i];
        end
    end

    // Stage 7: scale the squares back to channel range or pass through.
    hsv2rgb_pkg::chan_t s7_chan_reg  [3];
    hsv2rgb_pkg::chan_t s7_chan_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (square_en_reg)
            begin
                s7_chan_next[i] = div_maxv(s6_sq_reg[i]);
            end
            else
            begin
                s7_chan_next[i] = s6_chan_reg[i];
            end
        end
    end

    assign red_level   = s7_chan_reg[0];
    assign green_level = s7_chan_reg[1];
    assign blue_level  = s7_chan_reg[2];

    // Datapath registers load with their stage.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_hue_reg  <= s1_hue_next;
            s1_prod_reg <= s1_prod_next;
            s1_val_reg  <= s1_val_next;
        end
        if (adv[1])
        begin
            s2_sector_reg <= s2_sector_next;
            s2_rem_reg    <= s2_rem_next;
            s2_chroma_reg <= s2_chroma_next;
            s2_val_reg    <= s2_val_next;
        end
        if (adv[2])
        begin
            s3_ramp_reg   <= s3_ramp_next;
            s3_chroma_reg <= s3_chroma_next;
            s3_m_reg      <= s3_m_next;
            s3_sector_reg <= s3_sector_next;
        end
        if (adv[3])
        begin
            s4_qest_reg   <= s4_qest_next;
            s4_ramp_reg   <= s4_ramp_next;
            s4_chroma_reg <= s4_chroma_next;
            s4_m_reg      <= s4_m_next;
            s4_sector_reg <= s4_sector_next;
        end
        if (adv[4])
        begin
            s5_chan_reg <= s5_chan_next;
        end
        if (adv[5])
        begin
            s6_sq_reg   <= s6_sq_next;
            s6_chan_reg <= s6_chan_next;
        end
        if (adv[6])
        begin
            s7_chan_reg <= s7_chan_next;
        end
    end

endmodule
